// ===== rtl/imtc_pkg.sv =====
// Shared types, codes and helpers for the instrument mode and tuning controller.
package imtc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPTS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PLUCKS    = 3'd7;

  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_FAULT    = 4'd1;
  localparam logic [3:0] EV_STOP     = 4'd2;
  localparam logic [3:0] EV_WAKE     = 4'd3;
  localparam logic [3:0] EV_COMPOSE  = 4'd4;
  localparam logic [3:0] EV_PRECOMP  = 4'd5;
  localparam logic [3:0] EV_TUNE     = 4'd6;
  localparam logic [3:0] EV_PERFORM  = 4'd7;
  localparam logic [3:0] EV_NOTEPLAY = 4'd8;
  localparam logic [3:0] EV_DONE     = 4'd9;
  localparam logic [3:0] EV_IDLE_TO  = 4'd10;

  localparam logic [1:0] DAMP_NONE   = 2'd0;
  localparam logic [1:0] DAMP_LIFT   = 2'd1;
  localparam logic [1:0] DAMP_ENGAGE = 2'd2;
  localparam logic [1:0] DAMP_ALL    = 2'd3;

  localparam logic [2:0] SIDE_NONE     = 3'd0;
  localparam logic [2:0] SIDE_HOME     = 3'd1;
  localparam logic [2:0] SIDE_PARK     = 3'd2;
  localparam logic [2:0] SIDE_REENERGY = 3'd3;
  localparam logic [2:0] SIDE_COMPOSE  = 3'd4;

  localparam logic signed [13:0] ANGLE_MIN = 14'sd160;
  localparam logic signed [13:0] ANGLE_MAX = 14'sd2720;

  typedef enum logic [7:0] {
    MODE_HOMING  = 8'b0000_0001,
    MODE_IDLE    = 8'b0000_0010,
    MODE_SLEEP   = 8'b0000_0100,
    MODE_PRECOMP = 8'b0000_1000,
    MODE_COMPOSE = 8'b0001_0000,
    MODE_TUNING  = 8'b0010_0000,
    MODE_PERFORM = 8'b0100_0000,
    MODE_ERROR   = 8'b1000_0000
  } mode_t;

  typedef enum logic [5:0] {
    PH_SELECT = 6'b00_0001,
    PH_SERVO  = 6'b00_0010,
    PH_PLUCK  = 6'b00_0100,
    PH_LISTEN = 6'b00_1000,
    PH_EVAL   = 6'b01_0000,
    PH_DONE   = 6'b10_0000
  } phase_t;

  typedef struct packed {
    logic [15:0] target_0;
    logic [15:0] target_1;
    logic [15:0] target_2;
    logic [11:0] tolerance;
    logic [11:0] step;
    logic [7:0]  attempt_limit;
    logic [15:0] settle_ms;
    logic [7:0]  plucks;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  event_code;
    logic [31:0] now_ms;
    logic        motor_fault;
    logic        homing_reached;
    logic        servo_ready;
    logic [15:0] measured_pitch;
    logic [11:0] servo_angle;
  } item_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  string_sel;
    logic [7:0]  attempt;
    logic [7:0]  pluck_cnt;
    logic [31:0] settle_start;
    logic [15:0] pitch_latch;
  } tune_state_t;

  typedef struct packed {
    tune_state_t st;
    logic        pluck;
    logic [1:0]  damper;
    logic        svalid;
    logic [11:0] sangle;
    logic        done;
  } tune_out_t;

  typedef struct packed {
    mode_t      mode;
    logic       enter_tune;
    logic [2:0] side;
    logic [3:0] note;
    logic [1:0] strc;
  } mode_out_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  tuning_phase;
    logic [1:0]  string_select;
    logic        pluck_request;
    logic [1:0]  damper_action;
    logic        servo_command_valid;
    logic [11:0] servo_command_angle;
    logic        done_request;
    logic        fault_request;
    logic [2:0]  side_action;
    logic [3:0]  preview_note;
    logic [1:0]  preview_string;
  } result_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    unique case (m)
      MODE_HOMING:  c = 3'd0;
      MODE_IDLE:    c = 3'd1;
      MODE_SLEEP:   c = 3'd2;
      MODE_PRECOMP: c = 3'd3;
      MODE_COMPOSE: c = 3'd4;
      MODE_TUNING:  c = 3'd5;
      MODE_PERFORM: c = 3'd6;
      MODE_ERROR:   c = 3'd7;
      default:      c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] phase_code(phase_t p);
    logic [2:0] c;
    unique case (p)
      PH_SELECT: c = 3'd0;
      PH_SERVO:  c = 3'd1;
      PH_PLUCK:  c = 3'd2;
      PH_LISTEN: c = 3'd3;
      PH_EVAL:   c = 3'd4;
      PH_DONE:   c = 3'd5;
      default:   c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/imtc_in_if.sv =====
// Update item channel: valid/ready handshake with the status payload.
interface imtc_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_code;
  logic [31:0] now_ms;
  logic        motor_fault;
  logic        homing_reached;
  logic        servo_ready;
  logic [15:0] measured_pitch;
  logic [11:0] servo_angle;

  modport source (
    output valid, event_code, now_ms, motor_fault, homing_reached, servo_ready,
           measured_pitch, servo_angle,
    input  ready
  );
  modport sink (
    input  valid, event_code, now_ms, motor_fault, homing_reached, servo_ready,
           measured_pitch, servo_angle,
    output ready
  );
endinterface

// ===== rtl/imtc_out_if.sv =====
// Result channel: valid/ready handshake with mode, tuning and action fields.
interface imtc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [2:0]  tuning_phase;
  logic [1:0]  string_select;
  logic        pluck_request;
  logic [1:0]  damper_action;
  logic        servo_command_valid;
  logic [11:0] servo_command_angle;
  logic        done_request;
  logic        fault_request;
  logic [2:0]  side_action;
  logic [3:0]  preview_note;
  logic [1:0]  preview_string;

  modport source (
    output valid, mode, tuning_phase, string_select, pluck_request, damper_action,
           servo_command_valid, servo_command_angle, done_request, fault_request,
           side_action, preview_note, preview_string,
    input  ready
  );
  modport sink (
    input  valid, mode, tuning_phase, string_select, pluck_request, damper_action,
           servo_command_valid, servo_command_angle, done_request, fault_request,
           side_action, preview_note, preview_string,
    output ready
  );
endinterface

// ===== rtl/imtc_tune.sv =====
// Tuning loop step: select, servo wait, pluck, listen, evaluate and correct.
module imtc_tune #(
  parameter int STRING_COUNT = 3
) (
  input  imtc_pkg::tune_state_t st,
  input  imtc_pkg::item_t       item,
  input  imtc_pkg::cfg_t        cfg,
  output imtc_pkg::tune_out_t   tout
);
  import imtc_pkg::*;

  logic [15:0]        target;
  logic signed [16:0] err;
  logic [16:0]        mag;
  logic signed [13:0] angle_adj;
  logic signed [13:0] angle_clamped;
  logic [31:0]        elapsed;

  always_comb begin
    unique case (st.string_sel)
      2'd0:    target = cfg.target_0;
      2'd1:    target = cfg.target_1;
      default: target = cfg.target_2;
    endcase
    err     = signed'({1'b0, st.pitch_latch}) - signed'({1'b0, target});
    mag     = err[16] ? 17'(-err) : 17'(err);
    elapsed = item.now_ms - st.settle_start;
    if (!err[16] && err != '0) begin
      angle_adj = signed'({2'b00, item.servo_angle}) - signed'({2'b00, cfg.step});
    end else begin
      angle_adj = signed'({2'b00, item.servo_angle}) + signed'({2'b00, cfg.step});
    end
    if (angle_adj < ANGLE_MIN) begin
      angle_clamped = ANGLE_MIN;
    end else if (angle_adj > ANGLE_MAX) begin
      angle_clamped = ANGLE_MAX;
    end else begin
      angle_clamped = angle_adj;
    end
  end

  always_comb begin
    tout        = '0;
    tout.st     = st;
    tout.damper = DAMP_NONE;
    unique case (st.phase)
      PH_SELECT: begin
        if ({1'b0, st.string_sel} >= 3'(STRING_COUNT)) begin
          tout.st.phase = PH_DONE;
          tout.done     = 1'b1;
        end else begin
          tout.st.attempt   = '0;
          tout.st.pluck_cnt = '0;
          tout.damper       = DAMP_LIFT;
          tout.st.phase     = PH_SERVO;
        end
      end
      PH_SERVO: begin
        if (item.servo_ready) begin
          tout.st.pluck_cnt = '0;
          tout.st.phase     = PH_PLUCK;
        end
      end
      PH_PLUCK: begin
        if (st.pluck_cnt < cfg.plucks) begin
          tout.pluck        = 1'b1;
          tout.st.pluck_cnt = st.pluck_cnt + 8'd1;
        end else begin
          tout.st.settle_start = item.now_ms;
          tout.st.phase        = PH_LISTEN;
        end
      end
      PH_LISTEN: begin
        if (elapsed >= {16'b0, cfg.settle_ms}) begin
          tout.st.pitch_latch = item.measured_pitch;
          tout.st.phase       = PH_EVAL;
        end
      end
      PH_EVAL: begin
        if (mag <= {5'b0, cfg.tolerance} || st.attempt >= cfg.attempt_limit) begin
          tout.damper        = DAMP_ENGAGE;
          tout.st.string_sel = st.string_sel + 2'd1;
          tout.st.phase      = PH_SELECT;
        end else begin
          tout.svalid       = 1'b1;
          tout.sangle       = angle_clamped[11:0];
          tout.st.attempt   = st.attempt + 8'd1;
          tout.st.pluck_cnt = '0;
          tout.st.phase     = PH_SERVO;
        end
      end
      PH_DONE: ;
      default: ;
    endcase
  end
endmodule

// ===== rtl/imtc_mode.sv =====
// Mode transitions with homing lock, exit/entry side actions and menu scrolling.
module imtc_mode #(
  parameter int STRING_COUNT     = 3,
  parameter int NOTES_PER_STRING = 12
) (
  input  imtc_pkg::mode_t     mode,
  input  logic [3:0]          ev,
  input  logic                homed,
  input  logic [3:0]          note,
  input  logic [1:0]          strc,
  output imtc_pkg::mode_out_t mout
);
  import imtc_pkg::*;

  mode_t nxt;
  logic  changed;

  always_comb begin
    nxt       = mode;
    mout.note = note;
    mout.strc = strc;
    if (ev == EV_FAULT) begin
      nxt = MODE_ERROR;
    end else begin
      unique case (mode)
        MODE_HOMING: begin
          if (ev == EV_STOP || ev == EV_DONE) nxt = MODE_IDLE;
        end
        MODE_IDLE: begin
          if (ev == EV_COMPOSE) nxt = MODE_COMPOSE;
          else if (ev == EV_IDLE_TO) nxt = MODE_SLEEP;
          else if (ev == EV_TUNE && homed) nxt = MODE_TUNING;
          else if (ev == EV_PRECOMP && homed) nxt = MODE_PRECOMP;
          else if (ev == EV_PERFORM && homed) nxt = MODE_PERFORM;
        end
        MODE_SLEEP: begin
          if (ev == EV_WAKE) nxt = MODE_IDLE;
        end
        MODE_TUNING, MODE_PERFORM: begin
          if (ev == EV_STOP || ev == EV_DONE) nxt = MODE_IDLE;
        end
        MODE_PRECOMP: begin
          if (ev == EV_STOP) nxt = MODE_IDLE;
          else if (ev == EV_COMPOSE) nxt = MODE_COMPOSE;
          else if (ev == EV_IDLE_TO) nxt = MODE_SLEEP;
          else if (ev == EV_PERFORM) begin
            mout.note = (note == 4'(NOTES_PER_STRING - 1)) ? 4'd0 : note + 4'd1;
          end else if (ev == EV_TUNE) begin
            mout.strc = (strc == 2'(STRING_COUNT - 1)) ? 2'd0 : strc + 2'd1;
          end
        end
        MODE_COMPOSE: begin
          if (ev == EV_STOP) nxt = MODE_IDLE;
          else if (ev == EV_PERFORM || ev == EV_DONE) nxt = MODE_PERFORM;
          else if (ev == EV_IDLE_TO) nxt = MODE_SLEEP;
        end
        MODE_ERROR: begin
          if (ev == EV_STOP) nxt = MODE_IDLE;
        end
        default: ;
      endcase
    end

    changed         = (nxt != mode);
    mout.mode       = nxt;
    mout.enter_tune = changed && nxt == MODE_TUNING;
    mout.side       = (changed && mode == MODE_SLEEP) ? SIDE_REENERGY : SIDE_NONE;
    if (changed) begin
      unique case (nxt)
        MODE_HOMING:  mout.side = SIDE_HOME;
        MODE_SLEEP:   mout.side = SIDE_PARK;
        MODE_COMPOSE: mout.side = SIDE_COMPOSE;
        MODE_PRECOMP: begin
          mout.note = '0;
          mout.strc = '0;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/instrument_mode_and_tuning_controller.sv =====
// Top level: input register, mode/tuning state, single-pass step, result register.
//
// Usage:
//   up  - update items (event code, time, motor and servo status, pitch, angle).
//   dn  - one result per item: mode, tuning phase, string, actuator requests,
//         side action and precompose menu choices.
//   cfg - write port for the eight tuning registers (targets, tolerance, step,
//         attempt limit, settle time, plucks per try); write only while idle.
// Timing:
//   An accepted item lands in the input register; once the result register is
//   free or being taken, the whole step (activity, transition, entry/exit
//   actions) is computed in one pass and loaded into the result register.
//   One item per cycle while dn keeps taking results.
// Reset:
//   rst (synchronous) puts the block in homing, tuning at string 0 / select,
//   registers at their defaults and both channels empty.
// Stall:
//   While dn is held off, the pending result stays put and one more item
//   can wait in the input register; up.ready drops only when both are full.
module instrument_mode_and_tuning_controller #(
  parameter int STRING_COUNT     = 3,
  parameter int NOTES_PER_STRING = 12
) (
  input logic                             clk,
  input logic                             rst,
  imtc_in_if.sink                         up,
  imtc_out_if.source                      dn,
  input logic                             cfg_we,
  input logic [imtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [imtc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import imtc_pkg::*;

  cfg_t        cfg;
  logic        in_vld;
  item_t       item;
  logic        advance;

  mode_t       mode_q, mode_n;
  logic        homed_q, homed_n;
  tune_state_t tst_q, tst_n;
  logic [3:0]  note_q;
  logic [1:0]  strc_q;

  tune_out_t   tout;
  mode_out_t   mout;
  result_t     res_q, res_n;
  logic        fault_skip;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_0      <= 16'd3136;
      cfg.target_1      <= 16'd3950;
      cfg.target_2      <= 16'd4699;
      cfg.tolerance     <= 12'd16;
      cfg.step          <= 12'd80;
      cfg.attempt_limit <= 8'd10;
      cfg.settle_ms     <= 16'd500;
      cfg.plucks        <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_0:  cfg.target_0      <= cfg_data;
        CFG_TARGET_1:  cfg.target_1      <= cfg_data;
        CFG_TARGET_2:  cfg.target_2      <= cfg_data;
        CFG_TOLERANCE: cfg.tolerance     <= cfg_data[11:0];
        CFG_STEP:      cfg.step          <= cfg_data[11:0];
        CFG_ATTEMPTS:  cfg.attempt_limit <= cfg_data[7:0];
        CFG_SETTLE:    cfg.settle_ms     <= cfg_data;
        CFG_PLUCKS:    cfg.plucks        <= cfg_data[7:0];
      endcase
    end
  end

  // input register
  assign advance  = in_vld && (!dn.valid || dn.ready);
  assign up.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (up.ready) begin
      in_vld <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      item <= '{event_code:     up.event_code,
                now_ms:         up.now_ms,
                motor_fault:    up.motor_fault,
                homing_reached: up.homing_reached,
                servo_ready:    up.servo_ready,
                measured_pitch: up.measured_pitch,
                servo_angle:    up.servo_angle};
    end
  end

  // step logic
  imtc_tune #(.STRING_COUNT(STRING_COUNT)) u_tune (
    .st   (tst_q),
    .item (item),
    .cfg  (cfg),
    .tout (tout)
  );

  assign fault_skip = item.motor_fault && mode_q != MODE_ERROR;

  always_comb begin
    homed_n = homed_q;
    if (!fault_skip && mode_q == MODE_HOMING && item.homing_reached) homed_n = 1'b1;
  end

  imtc_mode #(
    .STRING_COUNT     (STRING_COUNT),
    .NOTES_PER_STRING (NOTES_PER_STRING)
  ) u_mode (
    .mode  (mode_q),
    .ev    (item.event_code),
    .homed (homed_n),
    .note  (note_q),
    .strc  (strc_q),
    .mout  (mout)
  );

  always_comb begin
    res_n  = '0;
    tst_n  = tst_q;
    mode_n = mout.mode;
    if (fault_skip) begin
      res_n.fault_request = 1'b1;
    end else if (mode_q == MODE_HOMING) begin
      res_n.done_request = item.homing_reached;
    end else if (mode_q == MODE_TUNING) begin
      tst_n                     = tout.st;
      res_n.pluck_request       = tout.pluck;
      res_n.damper_action       = tout.damper;
      res_n.servo_command_valid = tout.svalid;
      res_n.servo_command_angle = tout.sangle;
      res_n.done_request        = tout.done;
    end
    if (mout.enter_tune) begin
      tst_n.phase         = PH_SELECT;
      tst_n.string_sel    = '0;
      tst_n.attempt       = '0;
      res_n.damper_action = DAMP_ALL;
    end
    res_n.side_action    = mout.side;
    res_n.mode           = mode_code(mode_n);
    res_n.tuning_phase   = phase_code(tst_n.phase);
    res_n.string_select  = tst_n.string_sel;
    res_n.preview_note   = mout.note;
    res_n.preview_string = mout.strc;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q  <= MODE_HOMING;
      homed_q <= 1'b0;
      tst_q   <= '{phase: PH_SELECT, default: '0};
      note_q  <= '0;
      strc_q  <= '0;
    end else if (advance) begin
      mode_q  <= mode_n;
      homed_q <= homed_n;
      tst_q   <= tst_n;
      note_q  <= mout.note;
      strc_q  <= mout.strc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn.valid <= 1'b0;
    end else if (advance) begin
      dn.valid <= 1'b1;
    end else if (dn.ready) begin
      dn.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_q <= res_n;
  end

  assign dn.mode                = res_q.mode;
  assign dn.tuning_phase        = res_q.tuning_phase;
  assign dn.string_select       = res_q.string_select;
  assign dn.pluck_request       = res_q.pluck_request;
  assign dn.damper_action       = res_q.damper_action;
  assign dn.servo_command_valid = res_q.servo_command_valid;
  assign dn.servo_command_angle = res_q.servo_command_angle;
  assign dn.done_request        = res_q.done_request;
  assign dn.fault_request       = res_q.fault_request;
  assign dn.side_action         = res_q.side_action;
  assign dn.preview_note        = res_q.preview_note;
  assign dn.preview_string      = res_q.preview_string;

  // checks
  a_string_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, tst_q.string_sel} <= 3'(STRING_COUNT))
    else $error("string index beyond string count");

  a_homed_sticky: assert property (@(posedge clk) disable iff (rst)
    homed_q |=> homed_q)
    else $error("homed flag dropped");

  a_no_rehome: assert property (@(posedge clk) disable iff (rst)
    mode_q != MODE_HOMING |=> mode_q != MODE_HOMING)
    else $error("homing re-entered without reset");

  a_angle_idle: assert property (@(posedge clk) disable iff (rst)
    dn.valid && !dn.servo_command_valid |-> dn.servo_command_angle == 12'd0)
    else $error("servo angle driven without command");

endmodule

// ===== verif/instrument_mode_and_tuning_controller_tb.sv =====
// Self-checking testbench for the instrument mode and tuning controller.
`timescale 1ns / 100ps

module instrument_mode_and_tuning_controller_tb;
  import imtc_pkg::*;

  localparam int STRINGS      = 3;
  localparam int NOTES        = 12;
  localparam int IDLE_PCT     = 20;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 4;

  typedef enum logic [2:0] {
    MD_HOMING, MD_IDLE, MD_SLEEP, MD_PRECOMP, MD_COMPOSE, MD_TUNING, MD_PERFORM, MD_ERROR
  } mode_code_e;

  typedef enum logic [2:0] {
    PHS_SELECT, PHS_SERVO, PHS_PLUCK, PHS_LISTEN, PHS_EVAL, PHS_DONE
  } phase_code_e;

  localparam cfg_t CFG_DEFAULTS = '{target_0: 16'd3136, target_1: 16'd3950,
                                    target_2: 16'd4699, tolerance: 12'd16, step: 12'd80,
                                    attempt_limit: 8'd10, settle_ms: 16'd500, plucks: 8'd1};

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  imtc_in_if up ();
  imtc_out_if dn ();

  instrument_mode_and_tuning_controller dut (
    .clk       (clk),
    .rst       (rst),
    .up        (up),
    .dn        (dn),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted block state
  cfg_t        tb_cfg;
  mode_code_e  pm_mode;
  logic        pm_homed;
  phase_code_e pm_phase;
  logic [1:0]  pm_string;
  logic [7:0]  pm_attempt;
  logic [7:0]  pm_plucks;
  logic [31:0] pm_settle_start;
  logic [15:0] pm_pitch;
  logic [3:0]  pm_note;
  logic [1:0]  pm_strc;

  result_t     expected_q[$];
  result_t     got;
  result_t     want;
  logic [31:0] clock_ms;
  logic        steady;
  int          fail_count = 0;
  int          sent_count;
  int          cycle_count = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    dn.ready <= 1'b0;
    forever begin
      @(posedge clk);
      dn.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic note_failure(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [11:0] seen, logic [11:0] wanted);
    if (seen !== wanted) begin
      note_failure($sformatf("%s: got %0d, expected %0d", name, seen, wanted));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && dn.valid && dn.ready) begin
      got = '{mode: dn.mode, tuning_phase: dn.tuning_phase, string_select: dn.string_select,
              pluck_request: dn.pluck_request, damper_action: dn.damper_action,
              servo_command_valid: dn.servo_command_valid,
              servo_command_angle: dn.servo_command_angle, done_request: dn.done_request,
              fault_request: dn.fault_request, side_action: dn.side_action,
              preview_note: dn.preview_note, preview_string: dn.preview_string};
      if (expected_q.size() == 0) begin
        note_failure("result with no request waiting");
      end else begin
        want = expected_q.pop_front();
        check_field("mode", 12'(got.mode), 12'(want.mode));
        check_field("tuning_phase", 12'(got.tuning_phase), 12'(want.tuning_phase));
        check_field("string_select", 12'(got.string_select), 12'(want.string_select));
        check_field("pluck_request", 12'(got.pluck_request), 12'(want.pluck_request));
        check_field("damper_action", 12'(got.damper_action), 12'(want.damper_action));
        check_field("servo_command_valid", 12'(got.servo_command_valid),
                    12'(want.servo_command_valid));
        check_field("servo_command_angle", got.servo_command_angle, want.servo_command_angle);
        check_field("done_request", 12'(got.done_request), 12'(want.done_request));
        check_field("fault_request", 12'(got.fault_request), 12'(want.fault_request));
        check_field("side_action", 12'(got.side_action), 12'(want.side_action));
        check_field("preview_note", 12'(got.preview_note), 12'(want.preview_note));
        check_field("preview_string", 12'(got.preview_string), 12'(want.preview_string));
      end
    end
  end

  function automatic logic [15:0] target_of(logic [1:0] s);
    case (s)
      2'd0:    return tb_cfg.target_0;
      2'd1:    return tb_cfg.target_1;
      default: return tb_cfg.target_2;
    endcase
  endfunction

  // One update step: mode activity, then transition with exit/entry actions.
  function automatic result_t predict_step(item_t it);
    result_t     r;
    mode_code_e  nx;
    logic [3:0]  ev;
    logic [31:0] elapsed;
    int          err;
    int          mag;
    int          a;
    r  = '0;
    ev = it.event_code;
    if (it.motor_fault && pm_mode != MD_ERROR) begin
      r.fault_request = 1'b1;
    end else if (pm_mode == MD_HOMING) begin
      if (it.homing_reached) begin
        pm_homed = 1'b1;
        r.done_request = 1'b1;
      end
    end else if (pm_mode == MD_TUNING) begin
      case (pm_phase)
        PHS_SELECT: begin
          if (pm_string >= STRINGS) begin
            pm_phase = PHS_DONE;
            r.done_request = 1'b1;
          end else begin
            pm_attempt = '0;
            pm_plucks = '0;
            r.damper_action = DAMP_LIFT;
            pm_phase = PHS_SERVO;
          end
        end
        PHS_SERVO: begin
          if (it.servo_ready) begin
            pm_plucks = '0;
            pm_phase = PHS_PLUCK;
          end
        end
        PHS_PLUCK: begin
          if (pm_plucks < tb_cfg.plucks) begin
            r.pluck_request = 1'b1;
            pm_plucks = pm_plucks + 8'd1;
          end else begin
            pm_settle_start = it.now_ms;
            pm_phase = PHS_LISTEN;
          end
        end
        PHS_LISTEN: begin
          elapsed = it.now_ms - pm_settle_start;
          if (elapsed >= {16'd0, tb_cfg.settle_ms}) begin
            pm_pitch = it.measured_pitch;
            pm_phase = PHS_EVAL;
          end
        end
        PHS_EVAL: begin
          err = int'(pm_pitch) - int'(target_of(pm_string));
          mag = (err < 0) ? -err : err;
          if (mag <= int'(tb_cfg.tolerance) || pm_attempt >= tb_cfg.attempt_limit) begin
            r.damper_action = DAMP_ENGAGE;
            pm_string = pm_string + 2'd1;
            pm_phase = PHS_SELECT;
          end else begin
            a = int'(it.servo_angle) + ((err > 0) ? -int'(tb_cfg.step) : int'(tb_cfg.step));
            if (a < int'(ANGLE_MIN)) a = int'(ANGLE_MIN);
            if (a > int'(ANGLE_MAX)) a = int'(ANGLE_MAX);
            r.servo_command_valid = 1'b1;
            r.servo_command_angle = a[11:0];
            pm_attempt = pm_attempt + 8'd1;
            pm_plucks = '0;
            pm_phase = PHS_SERVO;
          end
        end
        default: ;
      endcase
    end

    if (ev != EV_NONE && ev <= EV_IDLE_TO) begin
      nx = pm_mode;
      if (ev == EV_FAULT) begin
        nx = MD_ERROR;
      end else begin
        case (pm_mode)
          MD_HOMING: if (ev == EV_STOP || ev == EV_DONE) nx = MD_IDLE;
          MD_IDLE: begin
            if (ev == EV_COMPOSE) nx = MD_COMPOSE;
            else if (ev == EV_IDLE_TO) nx = MD_SLEEP;
            else if (ev == EV_TUNE && pm_homed) nx = MD_TUNING;
            else if (ev == EV_PRECOMP && pm_homed) nx = MD_PRECOMP;
            else if (ev == EV_PERFORM && pm_homed) nx = MD_PERFORM;
          end
          MD_SLEEP: if (ev == EV_WAKE) nx = MD_IDLE;
          MD_TUNING, MD_PERFORM: if (ev == EV_STOP || ev == EV_DONE) nx = MD_IDLE;
          MD_PRECOMP: begin
            if (ev == EV_STOP) nx = MD_IDLE;
            else if (ev == EV_COMPOSE) nx = MD_COMPOSE;
            else if (ev == EV_IDLE_TO) nx = MD_SLEEP;
            else if (ev == EV_PERFORM) pm_note = 4'((int'(pm_note) + 1) % NOTES);
            else if (ev == EV_TUNE) pm_strc = 2'((int'(pm_strc) + 1) % STRINGS);
          end
          MD_COMPOSE: begin
            if (ev == EV_STOP) nx = MD_IDLE;
            else if (ev == EV_PERFORM || ev == EV_DONE) nx = MD_PERFORM;
            else if (ev == EV_IDLE_TO) nx = MD_SLEEP;
          end
          MD_ERROR: if (ev == EV_STOP) nx = MD_IDLE;
          default: ;
        endcase
      end
      if (nx != pm_mode) begin
        if (pm_mode == MD_SLEEP) r.side_action = SIDE_REENERGY;
        pm_mode = nx;
        case (nx)
          MD_HOMING:  r.side_action = SIDE_HOME;
          MD_SLEEP:   r.side_action = SIDE_PARK;
          MD_COMPOSE: r.side_action = SIDE_COMPOSE;
          MD_PRECOMP: begin
            pm_note = '0;
            pm_strc = '0;
          end
          MD_TUNING: begin
            pm_phase = PHS_SELECT;
            pm_string = '0;
            pm_attempt = '0;
            r.damper_action = DAMP_ALL;
          end
          default: ;
        endcase
      end
    end

    r.mode           = pm_mode;
    r.tuning_phase   = pm_phase;
    r.string_select  = pm_string;
    r.preview_note   = pm_note;
    r.preview_string = pm_strc;
    return r;
  endfunction

  function automatic item_t mk(logic [3:0] ev, logic [31:0] now, logic mf, logic hr,
                               logic sr, logic [15:0] pitch, logic [11:0] angle);
    item_t it;
    it.event_code     = ev;
    it.now_ms         = now;
    it.motor_fault    = mf;
    it.homing_reached = hr;
    it.servo_ready    = sr;
    it.measured_pitch = pitch;
    it.servo_angle    = angle;
    return it;
  endfunction

  // time moves mostly in steps up to a quarter of the settle time, sometimes up to twice it, now and then it jumps far
  function automatic logic [31:0] next_now();
    int unsigned span;
    int unsigned roll;
    span = 32'(tb_cfg.settle_ms);
    roll = $urandom_range(99);
    if (roll < 70) clock_ms = clock_ms + $urandom_range(span / 4 + 3);
    else if (roll < 95) clock_ms = clock_ms + $urandom_range(2 * span + 3);
    else clock_ms = clock_ms + $urandom;
    return clock_ms;
  endfunction

  function automatic item_t ctrl(logic [3:0] ev);
    return mk(ev, next_now(), 1'b0, 1'($urandom), 1'($urandom), 16'($urandom),
              12'($urandom_range(2880)));
  endfunction

  function automatic item_t noise_item();
    return mk(4'($urandom_range(15)), next_now(), $urandom_range(99) < 10, 1'($urandom),
              1'($urandom), 16'($urandom), 12'($urandom_range(2880)));
  endfunction

  function automatic item_t tuning_item();
    item_t       it;
    int unsigned tol;
    logic [15:0] aim;
    it  = mk(EV_NONE, next_now(), $urandom_range(99) < 3, 1'($urandom),
             $urandom_range(99) < 70, 16'($urandom), 12'($urandom_range(2880)));
    tol = 32'(tb_cfg.tolerance);
    aim = target_of(pm_string);
    if ($urandom_range(99) < 4) it.event_code = 4'($urandom_range(15));
    if ($urandom_range(99) < 40) it.measured_pitch = 16'(aim + $urandom_range(2 * tol + 2) - tol - 1);
    return it;
  endfunction

  task automatic send_item(item_t it);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      up.valid <= 1'b0;
      @(posedge clk);
    end
    up.valid          <= 1'b1;
    up.event_code     <= it.event_code;
    up.now_ms         <= it.now_ms;
    up.motor_fault    <= it.motor_fault;
    up.homing_reached <= it.homing_reached;
    up.servo_ready    <= it.servo_ready;
    up.measured_pitch <= it.measured_pitch;
    up.servo_angle    <= it.servo_angle;
    @(posedge clk);
    while (!up.ready) @(posedge clk);
    expected_q.push_back(predict_step(it));
    sent_count++;
  endtask

  task automatic settle_block();
    up.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_TARGET_0:  tb_cfg.target_0 = data;
      CFG_TARGET_1:  tb_cfg.target_1 = data;
      CFG_TARGET_2:  tb_cfg.target_2 = data;
      CFG_TOLERANCE: tb_cfg.tolerance = data[11:0];
      CFG_STEP:      tb_cfg.step = data[11:0];
      CFG_ATTEMPTS:  tb_cfg.attempt_limit = data[7:0];
      CFG_SETTLE:    tb_cfg.settle_ms = data;
      CFG_PLUCKS:    tb_cfg.plucks = data[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_settings(cfg_t c);
    settle_block();
    write_reg(CFG_TARGET_0, c.target_0);
    write_reg(CFG_TARGET_1, c.target_1);
    write_reg(CFG_TARGET_2, c.target_2);
    write_reg(CFG_TOLERANCE, {4'd0, c.tolerance});
    write_reg(CFG_STEP, {4'd0, c.step});
    write_reg(CFG_ATTEMPTS, {8'd0, c.attempt_limit});
    write_reg(CFG_SETTLE, c.settle_ms);
    write_reg(CFG_PLUCKS, {8'd0, c.plucks});
    cfg_we <= 1'b0;
  endtask

  task automatic go_idle();
    while (pm_mode != MD_IDLE) send_item(ctrl((pm_mode == MD_SLEEP) ? EV_WAKE : EV_STOP));
  endtask

  // enter tuning, run the string loop until done or out of budget, then leave
  task automatic run_tuning(int budget);
    int n;
    go_idle();
    send_item(ctrl(EV_TUNE));
    n = 0;
    while (n < budget && pm_mode == MD_TUNING && pm_phase != PHS_DONE) begin
      send_item(tuning_item());
      n++;
    end
    if (pm_mode == MD_TUNING) begin
      send_item(tuning_item());
      send_item(ctrl(($urandom_range(1) != 0) ? EV_DONE : EV_STOP));
    end
  endtask

  task automatic tuning_quota(int quota);
    int start;
    start = sent_count;
    while (sent_count - start < quota) run_tuning(150);
  endtask

  task automatic test_mode_walk();
    send_item(mk(EV_NONE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'h0000, 12'd0));
    send_item(mk(EV_TUNE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 16'hFFFF, 12'd2880));
    send_item(mk(4'd15, 32'h0000_0010, 1'b0, 1'b0, 1'b0, 16'h1234, 12'd100));
    // fault masks the homing check
    send_item(mk(EV_NONE, 32'h0000_0020, 1'b1, 1'b1, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_NONE, 32'h0000_0030, 1'b0, 1'b1, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_DONE, 32'h0000_0040, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_IDLE_TO, 32'h0000_0050, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_NONE, 32'h0000_0060, 1'b1, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_WAKE, 32'h0000_0070, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_PRECOMP, 32'h0000_0080, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_PERFORM, 32'h0000_0090, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_TUNE, 32'h0000_00A0, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_NOTEPLAY, 32'h0000_00B0, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_COMPOSE, 32'h0000_00C0, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_DONE, 32'h0000_00D0, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_STOP, 32'h0000_00E0, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_FAULT, 32'h0000_00F0, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    // error to error runs no actions, motor fault ignored here
    send_item(mk(EV_FAULT, 32'h0000_0100, 1'b1, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_STOP, 32'h0000_0110, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_TUNE, 32'hFFFF_FF00, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_NONE, 32'hFFFF_FF10, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_NONE, 32'hFFFF_FF20, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_NONE, 32'hFFFF_FF30, 1'b0, 1'b0, 1'b1, 16'h0, 12'd0));
    send_item(mk(EV_NONE, 32'hFFFF_FF40, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    send_item(mk(EV_NONE, 32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0, 16'h0, 12'd0));
    // settle window spans the time wrap; the latched pitch is used, not the next one
    send_item(mk(EV_NONE, 32'h0000_0200, 1'b0, 1'b0, 1'b0, 16'hFFFF, 12'd0));
    send_item(mk(EV_NONE, 32'h0000_0210, 1'b0, 1'b0, 1'b0, 16'h0000, 12'd0));
    clock_ms = 32'h0000_0210;
  endtask

  task automatic test_tuning_defaults();
    load_settings(CFG_DEFAULTS);
    steady = 1'b1;
    tuning_quota(150);
    steady = 1'b0;
    tuning_quota(150);
  endtask

  task automatic test_tuning_zero_settings();
    load_settings('{target_0: 16'd0, target_1: 16'd0, target_2: 16'd0, tolerance: 12'd0,
                    step: 12'd0, attempt_limit: 8'd0, settle_ms: 16'd0, plucks: 8'd0});
    tuning_quota(200);
  endtask

  task automatic test_tuning_max_settings();
    load_settings('{target_0: 16'hFFFF, target_1: 16'hFFFF, target_2: 16'hFFFF,
                    tolerance: 12'd4095, step: 12'd2880, attempt_limit: 8'd255,
                    settle_ms: 16'hFFFF, plucks: 8'd255});
    tuning_quota(300);
  endtask

  task automatic test_tuning_random_settings();
    cfg_t c;
    repeat (3) begin
      c.target_0      = 16'($urandom);
      c.target_1      = 16'($urandom);
      c.target_2      = 16'($urandom);
      c.tolerance     = 12'($urandom_range(64));
      c.step          = 12'($urandom_range(400));
      c.attempt_limit = 8'($urandom_range(6));
      c.settle_ms     = 16'($urandom_range(1000));
      c.plucks        = 8'($urandom_range(3));
      load_settings(c);
      tuning_quota(200);
    end
  endtask

  task automatic test_precompose_menu();
    int unsigned roll;
    logic [3:0]  ev;
    repeat (3) begin
      go_idle();
      send_item(ctrl(EV_PRECOMP));
      repeat (40) begin
        roll = $urandom_range(99);
        if (roll < 40) ev = EV_PERFORM;
        else if (roll < 70) ev = EV_TUNE;
        else if (roll < 80) ev = EV_NOTEPLAY;
        else if (roll < 90) ev = EV_NONE;
        else ev = 4'($urandom_range(15, 11));
        send_item(ctrl(ev));
      end
    end
  endtask

  task automatic test_random_events();
    repeat (100) send_item(noise_item());
    settle_block();
    repeat (100) send_item(noise_item());
  endtask

  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    up.valid          <= 1'b0;
    up.event_code     <= EV_NONE;
    up.now_ms         <= '0;
    up.motor_fault    <= 1'b0;
    up.homing_reached <= 1'b0;
    up.servo_ready    <= 1'b0;
    up.measured_pitch <= '0;
    up.servo_angle    <= '0;
    tb_cfg          = CFG_DEFAULTS;
    pm_mode         = MD_HOMING;
    pm_homed        = 1'b0;
    pm_phase        = PHS_SELECT;
    pm_string       = '0;
    pm_attempt      = '0;
    pm_plucks       = '0;
    pm_settle_start = '0;
    pm_pitch        = '0;
    pm_note         = '0;
    pm_strc         = '0;
    clock_ms        = $urandom;
    steady          = 1'b0;
    sent_count      = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_mode_walk();
    test_tuning_defaults();
    test_tuning_zero_settings();
    test_tuning_max_settings();
    test_tuning_random_settings();
    test_precompose_menu();
    test_random_events();

    settle_block();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
